// ----- src/ins_pkg.sv -----
// ----------------------------------------------------------------------------
// ins_pkg
// Shared item types and constants for the insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ins_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPW     = $clog2(QDEPTH);
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
    logic                      overflow;
  } out_item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  typedef enum logic [1:0] {
    ST_INSERT = 2'b01,
    ST_DRAIN  = 2'b10
  } back_state_t;

endpackage

`default_nettype wire

// ----- src/ins_front.sv -----
// ----------------------------------------------------------------------------
// ins_front
// Input queue: accepts items and hands them to the back end in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ins_front import ins_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t data,
  output q_head_t  head,
  input  logic     take
);

  in_item_t           slots [QDEPTH];
  logic [QPW-1:0]     wr_ptr;
  logic [QPW-1:0]     rd_ptr;
  logic [QCW-1:0]     count;
  logic [QCW-1:0]     count_next;
  logic               do_push;
  logic               do_take;

  assign full    = (count == QCW'(QDEPTH));
  assign do_push = push && !full;
  assign do_take = take && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_comb begin
    case ({do_push, do_take})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_take) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= data;
  end

endmodule

`default_nettype wire

// ----- src/ins_back.sv -----
// ----------------------------------------------------------------------------
// ins_back
// Insertion cell chain with shift-out drain and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ins_back import ins_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  q_head_t   head,
  output logic      take,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] store [DEPTH];
  logic [DEPTH-1:0]          ins;
  logic [CW-1:0]             fill;
  logic                      dropped;
  logic                      has_room;
  logic                      do_insert;
  logic                      do_emit;
  logic                      out_valid;
  back_state_t               state;

  assign take      = (state == ST_INSERT) && head.valid;
  assign has_room  = (fill != CW'(DEPTH));
  assign do_insert = take && has_room;
  assign do_emit   = (state == ST_DRAIN) && (!out_valid || pop);
  assign empty     = !out_valid;

  // per cell: the new value lands here or pushes this entry up
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);

    assign ins[i] = (IDX >= fill) || (head.item.value < store[i]);

    always_ff @(posedge clk) begin
      if (do_insert && ins[i]) begin
        if (i > 0 && ins[(i > 0) ? i - 1 : 0]) store[i] <= store[(i > 0) ? i - 1 : 0];
        else store[i] <= head.item.value;
      end else if (do_emit) begin
        if (i < DEPTH - 1) store[i] <= store[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INSERT;
      fill      <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_INSERT: begin
          if (take) begin
            if (has_room) fill <= fill + 1'b1;
            else dropped <= 1'b1;
            if (head.item.last) state <= ST_DRAIN;
          end
          if (pop) out_valid <= 1'b0;
        end
        ST_DRAIN: begin
          if (do_emit) begin
            out_valid <= 1'b1;
            fill      <= fill - 1'b1;
            if (fill == CW'(1)) begin
              dropped <= 1'b0;
              state   <= ST_INSERT;
            end
          end
        end
        default: state <= ST_INSERT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      result.sorted_value <= store[0];
      result.final_res    <= (fill == CW'(1));
      result.overflow     <= dropped;
    end
  end

endmodule

`default_nettype wire

// ----- src/insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter
// Streaming insertion sorter for signed 32-bit arrays.
// ----------------------------------------------------------------------------
// Items carry one signed value each; an item with last set closes an array.
// A two-entry input queue takes items while the sorter is busy. The back end
// is a chain of DEPTH insertion cells: each queued item is inserted as the
// queue hands it over (every cell compares in parallel and either keeps,
// shifts up, or captures the new value). Equal values land after the ones
// already held, keeping arrival order. After the last value the chain
// shifts out toward cell 0, one result per cycle while pop keeps up, with
// one result for each value held; no insertion happens during that drain,
// though the input queue still fills. Values past DEPTH are dropped and
// every result of that array has overflow set. final_res marks the last
// result of an array. No clearing is needed after reset.
`default_nettype none

module insertion_sorter import ins_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  // input side
  input  logic      push,
  output logic      full,
  input  in_item_t  data,
  // result side
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  q_head_t head;
  logic    take;

  // front: input queue
  ins_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .data (data),
    .head (head),
    .take (take)
  );

  // back: insertion cells, drain and result register
  ins_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

// ----- src/insertion_sorter_checker.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter_checker
// Port-level checks for the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter_checker import ins_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // nothing waits and nothing is blocked right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("sorter not empty after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("result changed while stalled");

  // inside a run the next result follows at once and keeps the overflow mark
  a_run: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !result.final_res |=>
      !empty && (result.overflow == $past(result.overflow)))
    else $error("sorted run broken or overflow changed");

  // the queue only turns full right after an item was pushed
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    full |-> $past(push) || $past(full))
    else $error("queue full without an item pushed");

endmodule

bind insertion_sorter insertion_sorter_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
